// ===== rtl/cldh_pkg.sv =====
// Shared types, constants and the segment fold for the cache line dedup hash block.
// Used by cldh_scan and cache_line_dedup_hash; depends on nothing.
package cldh_pkg;

	localparam int MAX_LINES   = 64;
	localparam int LINE_WORDS  = 8;
	localparam int IDX_W       = 6;
	localparam int POS_W       = 3;
	localparam int HELD_W      = 7;
	localparam int ADDR_W      = IDX_W + POS_W;
	localparam int STORE_DEPTH = MAX_LINES * LINE_WORDS;

	localparam logic [HELD_W-1:0] MAX_HELD   = HELD_W'(MAX_LINES);
	localparam logic [POS_W-1:0]  LAST_POS   = POS_W'(LINE_WORDS - 1);
	localparam logic [6:0]        LINE_BYTES = 7'd64;

	localparam logic CMD_WORD  = 1'b0;
	localparam logic CMD_CLEAR = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic              start;
		logic              first;
		logic              last;
		logic [POS_W-1:0]  pos;
		logic [HELD_W-1:0] held;
		logic              wr_en;
		logic [IDX_W-1:0]  wr_slot;
	} scan_ctl_t;

	typedef struct packed {
		logic             done;
		logic             found;
		logic [IDX_W-1:0] match;
	} scan_res_t;

	function automatic logic [15:0] word_fold(input logic [63:0] w);
		logic [15:0] acc;
		acc = '0;
		for (int k = 0; k < 4; k++) begin
			acc = acc ^ {w[16*k +: 8], w[16*k+8 +: 8]};
		end
		return acc;
	endfunction

endpackage

// ===== rtl/cldh_scan.sv =====
// Line store and word compare engine: one store read per cycle over all held lines.
// Depends on cldh_pkg.
module cldh_scan
	import cldh_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  scan_ctl_t   ctl,
	input  logic [63:0] word,
	output scan_res_t   res
);

	logic [63:0] store_mem [STORE_DEPTH];

	logic              active_q;
	logic [63:0]       word_q;
	logic [POS_W-1:0]  pos_q;
	logic              first_q;
	logic              last_q;
	logic [HELD_W-1:0] held_q;
	logic [HELD_W-1:0] idx_q;
	logic              vld_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic [63:0]       rd_data_s1;
	logic [MAX_LINES-1:0] mask_q;
	logic              found_q;
	logic [IDX_W-1:0]  match_q;

	logic              done;
	logic              cand;
	logic [ADDR_W-1:0] rd_addr;

	assign rd_addr = {idx_q[IDX_W-1:0], pos_q};
	assign done    = active_q && (idx_q == held_q) && !vld_s1;
	assign cand    = (rd_data_s1 == word_q) && (first_q || mask_q[idx_s1]);

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			store_mem[{ctl.wr_slot, ctl.pos}] <= word;
		end
		rd_data_s1 <= store_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			word_q  <= word;
			pos_q   <= ctl.pos;
			first_q <= ctl.first;
			last_q  <= ctl.last;
			held_q  <= ctl.held;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			idx_q    <= '0;
			vld_s1   <= 1'b0;
			idx_s1   <= '0;
			mask_q   <= '0;
			found_q  <= 1'b0;
			match_q  <= '0;
		end else if (ctl.start) begin
			active_q <= 1'b1;
			idx_q    <= '0;
			vld_s1   <= 1'b0;
			found_q  <= 1'b0;
			match_q  <= '0;
		end else if (active_q) begin
			if (idx_q < held_q) begin
				idx_q  <= idx_q + 1'b1;
				vld_s1 <= 1'b1;
				idx_s1 <= idx_q[IDX_W-1:0];
			end else begin
				vld_s1 <= 1'b0;
			end
			if (vld_s1) begin
				mask_q[idx_s1] <= cand;
				if (last_q && cand && !found_q) begin
					found_q <= 1'b1;
					match_q <= idx_s1;
				end
			end
			if (done) begin
				active_q <= 1'b0;
			end
		end
	end

	assign res.done  = done;
	assign res.found = found_q;
	assign res.match = match_q;

endmodule

// ===== rtl/cache_line_dedup_hash.sv =====
// Top level of the cache line dedup hash block: beat intake, line hash, shared flags, result.
// Depends on cldh_pkg and cldh_scan.
//
// Usage: a line arrives as eight input beats (cmd = word), first word first, on
// in_valid / in_stall. Each word beat is compared against the same word of every
// held line, one line store read per cycle, and in_stall is high while the scan
// runs. The beat that completes a line then passes through the emit state, which
// waits until the output is free, loads the result register and drives one
// result beat on out_valid / out_stall: hash, duplicate flag, size, matched line,
// matched-was-shared flag, slot and full flag.
// A clear beat (cmd = clear) empties the store and counters,
// drops any partial line and gives no result.
// While out_stall holds a result, the block keeps accepting beats; only the next
// completing line waits until the held result is taken.
// Reset empties the store, clears the shared flags and counters and drops any
// pending result; no clearing pass is needed.
module cache_line_dedup_hash
	import cldh_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        cmd,
	input  logic [63:0] line_word,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] line_hash,
	output logic        is_duplicate,
	output logic [6:0]  dedup_bytes,
	output logic [5:0]  matched_line,
	output logic        matched_was_shared,
	output logic [5:0]  line_index,
	output logic        store_full
);

	state_t state_q;
	state_t state_d;

	logic [HELD_W-1:0]    held_q;
	logic [POS_W-1:0]     pos_q;
	logic [15:0]          hash_q;
	logic [MAX_LINES-1:0] shared_q;
	logic                 last_q;
	logic                 out_valid_q;

	logic      accept;
	logic      word_beat;
	logic      clear_beat;
	logic      emit;
	logic      out_free;
	logic      full;
	scan_ctl_t scan_ctl;
	scan_res_t scan_res;

	assign accept     = in_valid && !in_stall;
	assign word_beat  = accept && (cmd == CMD_WORD);
	assign clear_beat = accept && (cmd == CMD_CLEAR);
	assign out_free   = !out_valid_q || !out_stall;
	assign full       = (held_q >= MAX_HELD);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (word_beat) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_res.done) begin
					state_d = last_q ? ST_EMIT : ST_IDLE;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall = 1'b1;
		emit     = 1'b0;
		case (state_q)
			ST_IDLE: in_stall = 1'b0;
			ST_SCAN: in_stall = 1'b1;
			ST_EMIT: emit     = out_free;
			default: in_stall = 1'b1;
		endcase
	end

	always_comb begin
		scan_ctl.start   = word_beat;
		scan_ctl.first   = (pos_q == '0);
		scan_ctl.last    = (pos_q == LAST_POS);
		scan_ctl.pos     = pos_q;
		scan_ctl.held    = held_q;
		scan_ctl.wr_en   = word_beat && !full;
		scan_ctl.wr_slot = held_q[IDX_W-1:0];
	end

	cldh_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (scan_ctl),
		.word   (line_word),
		.res    (scan_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			held_q      <= '0;
			pos_q       <= '0;
			hash_q      <= '0;
			shared_q    <= '0;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (clear_beat) begin
				held_q   <= '0;
				pos_q    <= '0;
				hash_q   <= '0;
				shared_q <= '0;
			end else if (word_beat) begin
				pos_q  <= pos_q + 1'b1;
				last_q <= (pos_q == LAST_POS);
				hash_q <= ((pos_q == '0) ? 16'h0000 : hash_q) ^ word_fold(line_word);
			end
			if (emit) begin
				out_valid_q <= 1'b1;
				if (scan_res.found) begin
					shared_q[scan_res.match] <= 1'b1;
				end
				if (!full) begin
					held_q <= held_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			line_hash          <= hash_q;
			is_duplicate       <= scan_res.found;
			dedup_bytes        <= scan_res.found ? 7'd0 : LINE_BYTES;
			matched_line       <= scan_res.found ? scan_res.match : '0;
			matched_was_shared <= scan_res.found && shared_q[scan_res.match];
			line_index         <= full ? '0 : held_q[IDX_W-1:0];
			store_full         <= full;
		end
	end

	assign out_valid = out_valid_q;

endmodule
